/* hw/rtl/lir_pkg.sv */
// ---------------------------------------------------------------------------
// lir_pkg
// Shared constants, types and helpers for the largest interior rectangle
// finder.
// ---------------------------------------------------------------------------
package lir_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int FW_W    = COL_W + 1;
    localparam int FH_W    = ROW_W + 1;
    localparam int HGT_W   = ROW_W + 1;
    localparam int DEPTH_W = COL_W + 1;
    localparam int AREA_W  = COL_W + ROW_W + 1;
    localparam int NW_W    = FW_W + 1;
    localparam int NH_W    = FH_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FW_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = FH_W'(MAX_HEIGHT);
    localparam logic [COL_W-1:0] RST_PAD_H        = COL_W'(50);
    localparam logic [ROW_W-1:0] RST_PAD_V        = ROW_W'(150);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_APPROX_MODE  = 3'd2,
        REG_PAD_H        = 3'd3,
        REG_PAD_V        = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [FW_W-1:0]  frame_width;
        logic [FH_W-1:0]  frame_height;
        logic             approximate_mode;
        logic [COL_W-1:0] pad_horizontal;
        logic [ROW_W-1:0] pad_vertical;
    } cfg_t;

    // classified pixel passed from front to back
    typedef struct packed {
        logic             bit_val;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             eol;
        logic             eof;
    } pixel_word_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [HGT_W-1:0] hgt;
    } stack_entry_t;

    function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] v);
        logic [FW_W-1:0] r;
        begin
            if (v == '0)
                r = FW_W'(1);
            else if (v > FW_W'(MAX_WIDTH))
                r = FW_W'(MAX_WIDTH);
            else
                r = v;
            return r;
        end
    endfunction

    function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] v);
        logic [FH_W-1:0] r;
        begin
            if (v == '0)
                r = FH_W'(1);
            else if (v > FH_W'(MAX_HEIGHT))
                r = FH_W'(MAX_HEIGHT);
            else
                r = v;
            return r;
        end
    endfunction

endpackage

/* hw/rtl/lir_front.sv */
// ---------------------------------------------------------------------------
// lir_front
// Accepts mask pixels, tracks raster position and tags row and frame ends.
// ---------------------------------------------------------------------------
module lir_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 mask_bit,
    input  logic                 q_full,
    input  lir_pkg::cfg_t        cfg,
    output logic                 q_push,
    output lir_pkg::pixel_word_t q_word
);

    logic [lir_pkg::COL_W-1:0] col_reg, col_next;
    logic [lir_pkg::ROW_W-1:0] row_reg, row_next;
    logic [lir_pkg::FW_W-1:0]  w_eff, col_plus;
    logic [lir_pkg::FH_W-1:0]  h_eff, row_plus;
    logic                      eol, eof;

    assign w_eff    = lir_pkg::eff_width(cfg.frame_width);
    assign h_eff    = lir_pkg::eff_height(cfg.frame_height);
    assign col_plus = {1'b0, col_reg} + lir_pkg::FW_W'(1);
    assign row_plus = {1'b0, row_reg} + lir_pkg::FH_W'(1);
    assign eol      = !(col_plus < w_eff);
    assign eof      = eol && !(row_plus < h_eff);
    assign q_push   = push && !q_full;

    always_comb
    begin
        q_word.bit_val = mask_bit;
        q_word.col     = col_reg;
        q_word.row     = row_reg;
        q_word.eol     = eol;
        q_word.eof     = eof;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (eol)
            begin
                col_next = '0;
                row_next = eof ? '0 : row_plus[lir_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_plus[lir_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hw/rtl/lir_queue.sv */
// ---------------------------------------------------------------------------
// lir_queue
// Short FIFO of classified pixel words between front and back.
// ---------------------------------------------------------------------------
module lir_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lir_pkg::pixel_word_t word_in,
    output logic                 full,
    input  logic                 pop,
    output lir_pkg::pixel_word_t word_out,
    output logic                 empty
);

    lir_pkg::pixel_word_t        slot_reg [lir_pkg::QUEUE_DEPTH];
    logic [lir_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lir_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lir_pkg::Q_PTR_W:0]   count_reg, count_next;
    logic                        do_push, do_pop;

    assign full     = (count_reg == (lir_pkg::Q_PTR_W+1)'(lir_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign word_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + lir_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lir_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (lir_pkg::Q_PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (lir_pkg::Q_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= word_in;
    end

endmodule

/* hw/rtl/lir_back.sv */
// ---------------------------------------------------------------------------
// lir_back
// Column height update, histogram stack scan, best rectangle tracking and
// result formatting with a one-word output register.
// ---------------------------------------------------------------------------
module lir_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lir_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  lir_pkg::pixel_word_t          q_word,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic                          rect_found,
    output logic [lir_pkg::COL_W-1:0]     rect_x,
    output logic [lir_pkg::ROW_W-1:0]     rect_y,
    output logic [lir_pkg::FW_W-1:0]      rect_width,
    output logic [lir_pkg::FH_W-1:0]      rect_height
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HGT   = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_FLUSH = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_RES1  = 7'b0100000,
        ST_RES2  = 7'b1000000
    } state_t;

    localparam int COL_W   = lir_pkg::COL_W;
    localparam int ROW_W   = lir_pkg::ROW_W;
    localparam int HGT_W   = lir_pkg::HGT_W;
    localparam int FW_W    = lir_pkg::FW_W;
    localparam int FH_W    = lir_pkg::FH_W;
    localparam int DEPTH_W = lir_pkg::DEPTH_W;
    localparam int AREA_W  = lir_pkg::AREA_W;
    localparam int NW_W    = lir_pkg::NW_W;
    localparam int NH_W    = lir_pkg::NH_W;

    state_t state_reg, state_next;

    // pixel in work
    lir_pkg::pixel_word_t px_reg, px_next;
    logic [HGT_W-1:0]     h_reg, h_next;

    // column heights
    logic [HGT_W-1:0] hmem [lir_pkg::MAX_WIDTH];
    logic [HGT_W-1:0] hmem_rdata;
    logic             h_re, h_we;

    // scan stack: top and second in registers, the rest in memory
    lir_pkg::stack_entry_t smem [lir_pkg::MAX_WIDTH];
    lir_pkg::stack_entry_t smem_rdata, sec, top_reg, top_next, sec_reg, sec_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic                  refill_reg, refill_next;
    logic                  s_we, s_re;
    logic [COL_W-1:0]      s_waddr, s_raddr;
    logic [DEPTH_W-1:0]    depth_m2, depth_m3;

    logic                do_pop, do_push;
    logic [FW_W-1:0]     pop_end;
    logic [FW_W-1:0]     col_plus;
    logic [HGT_W:0]      h_sum;
    logic [HGT_W-1:0]    h_lim;

    // candidate pipeline
    logic             a_valid_reg;
    logic [HGT_W-1:0] a_h_reg;
    logic [COL_W-1:0] a_left_reg;
    logic [FW_W-1:0]  a_w_reg;
    logic [ROW_W-1:0] a_top_reg;
    logic [COL_W-1:0] cand_left;
    logic [HGT_W-1:0] cand_top;
    logic [HGT_W+FW_W-1:0] a_prod;

    logic              b_valid_reg;
    logic [AREA_W-1:0] b_area_reg;
    logic [HGT_W-1:0]  b_h_reg;
    logic [COL_W-1:0]  b_left_reg;
    logic [FW_W-1:0]   b_w_reg;
    logic [ROW_W-1:0]  b_top_reg;

    logic [AREA_W-1:0] best_area_reg;
    logic [COL_W-1:0]  best_left_reg;
    logic [ROW_W-1:0]  best_top_reg;
    logic [FW_W-1:0]   best_cols_reg;
    logic [HGT_W-1:0]  best_rows_reg;
    logic              best_clear;

    // result formatting
    logic             r_found_reg;
    logic [COL_W-1:0] r_x_reg;
    logic [ROW_W-1:0] r_y_reg;
    logic [NW_W-1:0]  r_nw_reg;
    logic [NH_W-1:0]  r_nh_reg;
    logic [FW_W-1:0]  w_eff, w_room, w_fit;
    logic [FH_W-1:0]  h_eff, h_room, h_fit;

    logic             out_valid_reg, out_valid_next, out_ready, out_load;
    logic             o_found;
    logic [COL_W-1:0] o_x;
    logic [ROW_W-1:0] o_y;
    logic [FW_W-1:0]  o_w;
    logic [FH_W-1:0]  o_h;

    assign sec      = refill_reg ? smem_rdata : sec_reg;
    assign col_plus = {1'b0, px_reg.col} + FW_W'(1);
    assign depth_m2 = depth_reg - DEPTH_W'(2);
    assign depth_m3 = depth_reg - DEPTH_W'(3);
    assign s_waddr  = depth_m2[COL_W-1:0];
    assign s_raddr  = depth_m3[COL_W-1:0];
    assign w_eff    = lir_pkg::eff_width(cfg.frame_width);
    assign h_eff    = lir_pkg::eff_height(cfg.frame_height);
    assign out_ready = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;

    // new run height from the stored one
    assign h_sum = {1'b0, hmem_rdata} + (HGT_W+1)'(1);
    assign h_lim = {1'b0, px_reg.row} + HGT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        h_next     = h_reg;
        q_pop      = 1'b0;
        h_re       = 1'b0;
        h_we       = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        pop_end    = {1'b0, px_reg.col};
        out_load   = 1'b0;
        best_clear = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    h_re       = 1'b1;
                    px_next    = q_word;
                    state_next = ST_HGT;
                end
            end
            ST_HGT:
            begin
                h_we = 1'b1;
                if (px_reg.row == '0 || !px_reg.bit_val)
                    h_next = HGT_W'(px_reg.bit_val);
                else if (h_sum > {1'b0, h_lim})
                    h_next = h_lim;
                else
                    h_next = h_sum[HGT_W-1:0];
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (depth_reg != '0 && top_reg.hgt > h_reg)
                begin
                    do_pop = 1'b1;
                end
                else
                begin
                    do_push    = 1'b1;
                    state_next = px_reg.eol ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                pop_end = col_plus;
                if (depth_reg != '0)
                    do_pop = 1'b1;
                else
                    state_next = px_reg.eof ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (!a_valid_reg && !b_valid_reg)
                    state_next = ST_RES1;
            end
            ST_RES1:
            begin
                state_next = ST_RES2;
            end
            ST_RES2:
            begin
                if (out_ready)
                begin
                    out_load   = 1'b1;
                    best_clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stack moves
    always_comb
    begin
        depth_next  = depth_reg;
        top_next    = top_reg;
        sec_next    = sec;
        refill_next = 1'b0;
        s_we        = 1'b0;
        s_re        = 1'b0;
        if (do_pop)
        begin
            depth_next  = depth_reg - DEPTH_W'(1);
            top_next    = sec;
            s_re        = (depth_reg >= DEPTH_W'(3));
            refill_next = s_re;
        end
        else if (do_push)
        begin
            depth_next   = depth_reg + DEPTH_W'(1);
            top_next.col = px_reg.col;
            top_next.hgt = h_reg;
            sec_next     = top_reg;
            s_we         = (depth_reg >= DEPTH_W'(2));
        end
    end

    // candidate of the popped column
    always_comb
    begin
        cand_left = (depth_reg >= DEPTH_W'(2)) ? sec.col + COL_W'(1) : '0;
        cand_top  = h_lim - top_reg.hgt;
        a_prod    = a_h_reg * a_w_reg;
    end

    // padding and clipping
    always_comb
    begin
        w_room = (w_eff > {1'b0, r_x_reg}) ? w_eff - {1'b0, r_x_reg} : '0;
        h_room = (h_eff > {1'b0, r_y_reg}) ? h_eff - {1'b0, r_y_reg} : '0;
        w_fit  = (r_nw_reg < {1'b0, w_room}) ? r_nw_reg[FW_W-1:0] : w_room;
        h_fit  = (r_nh_reg < {1'b0, h_room}) ? r_nh_reg[FH_W-1:0] : h_room;
        o_found = r_found_reg;
        o_x     = '0;
        o_y     = '0;
        o_w     = '0;
        o_h     = '0;
        if (r_found_reg)
        begin
            if (cfg.approximate_mode)
            begin
                o_x = r_x_reg;
                o_y = r_y_reg;
                o_w = w_fit;
                o_h = h_fit;
            end
            else
            begin
                o_x = best_left_reg;
                o_y = best_top_reg;
                o_w = best_cols_reg;
                o_h = best_rows_reg;
            end
        end
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            refill_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            best_area_reg <= '0;
            best_left_reg <= '0;
            best_top_reg  <= '0;
            best_cols_reg <= '0;
            best_rows_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            refill_reg    <= refill_next;
            a_valid_reg   <= do_pop;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= out_valid_next;
            if (best_clear)
            begin
                best_area_reg <= '0;
                best_left_reg <= '0;
                best_top_reg  <= '0;
                best_cols_reg <= '0;
                best_rows_reg <= '0;
            end
            else if (b_valid_reg && b_area_reg > best_area_reg)
            begin
                best_area_reg <= b_area_reg;
                best_left_reg <= b_left_reg;
                best_top_reg  <= b_top_reg;
                best_cols_reg <= b_w_reg;
                best_rows_reg <= b_h_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        h_reg   <= h_next;
        top_reg <= top_next;
        sec_reg <= sec_next;

        a_h_reg    <= top_reg.hgt;
        a_left_reg <= cand_left;
        a_w_reg    <= pop_end - {1'b0, cand_left};
        a_top_reg  <= cand_top[ROW_W-1:0];

        b_area_reg <= a_prod[AREA_W-1:0];
        b_h_reg    <= a_h_reg;
        b_left_reg <= a_left_reg;
        b_w_reg    <= a_w_reg;
        b_top_reg  <= a_top_reg;

        r_found_reg <= (best_area_reg != '0);
        r_x_reg     <= (best_left_reg > cfg.pad_horizontal) ?
                       best_left_reg - cfg.pad_horizontal : '0;
        r_y_reg     <= (best_top_reg > cfg.pad_vertical) ?
                       best_top_reg - cfg.pad_vertical : '0;
        r_nw_reg    <= {1'b0, best_cols_reg} + {1'b0, cfg.pad_horizontal, 1'b0};
        r_nh_reg    <= {1'b0, best_rows_reg} + {1'b0, cfg.pad_vertical, 1'b0};

        if (out_load)
        begin
            rect_found  <= o_found;
            rect_x      <= o_x;
            rect_y      <= o_y;
            rect_width  <= o_w;
            rect_height <= o_h;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            hmem[px_reg.col] <= h_next;
        if (h_re)
            hmem_rdata <= hmem[q_word.col];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[s_waddr] <= sec;
        if (s_re)
            smem_rdata <= smem[s_raddr];
    end

endmodule

/* hw/rtl/largest_interior_rectangle.sv */
// ---------------------------------------------------------------------------
// largest_interior_rectangle
// Largest all-set rectangle in a raster binary mask, one result per frame.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | words
//  ---------+-----------+-------------------------+---------------------------
//  pixels   | in        | push / full             | mask_bit
//  result   | out       | empty / pop             | rect_found, rect_x, rect_y,
//           |           |                         | rect_width, rect_height
//  config   | in        | cfg_write               | cfg_index, cfg_data
//
//  In the back end a pixel passes the IDLE, HGT and SCAN states, and SCAN
//  pops the single-port stack one entry at a time; each row end flushes
//  the remaining stack entries. A frame end drains the candidate pipeline
//  and formats the result. A 4-word queue lets the pixel side run ahead of
//  the scan. The result waits in an output register; pixels of the next
//  frame are still taken while it waits. Reset needs no sweep.
// ---------------------------------------------------------------------------
module largest_interior_rectangle (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              mask_bit,
    output logic                              empty,
    input  logic                              pop,
    output logic                              rect_found,
    output logic [lir_pkg::COL_W-1:0]         rect_x,
    output logic [lir_pkg::ROW_W-1:0]         rect_y,
    output logic [lir_pkg::FW_W-1:0]          rect_width,
    output logic [lir_pkg::FH_W-1:0]          rect_height,
    input  logic                              cfg_write,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lir_pkg::cfg_t        cfg_reg;
    lir_pkg::pixel_word_t f_word, q_word;
    logic                 f_push, q_empty, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width      <= lir_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height     <= lir_pkg::RST_FRAME_HEIGHT;
            cfg_reg.approximate_mode <= 1'b0;
            cfg_reg.pad_horizontal   <= lir_pkg::RST_PAD_H;
            cfg_reg.pad_vertical     <= lir_pkg::RST_PAD_V;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lir_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data[lir_pkg::FW_W-1:0];
                lir_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[lir_pkg::FH_W-1:0];
                lir_pkg::REG_APPROX_MODE:
                    cfg_reg.approximate_mode <= cfg_data[0];
                lir_pkg::REG_PAD_H:
                    cfg_reg.pad_horizontal <= cfg_data[lir_pkg::COL_W-1:0];
                lir_pkg::REG_PAD_V:
                    cfg_reg.pad_vertical <= cfg_data[lir_pkg::ROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lir_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .mask_bit (mask_bit),
        .q_full   (full),
        .cfg      (cfg_reg),
        .q_push   (f_push),
        .q_word   (f_word)
    );

    lir_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .word_in  (f_word),
        .full     (full),
        .pop      (q_pop),
        .word_out (q_word),
        .empty    (q_empty)
    );

    lir_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .rect_found  (rect_found),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height)
    );

endmodule

/* hw/rtl/lir_checker.sv */
// ---------------------------------------------------------------------------
// lir_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module lir_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic                          rect_found,
    input logic [lir_pkg::COL_W-1:0]     rect_x,
    input logic [lir_pkg::ROW_W-1:0]     rect_y,
    input logic [lir_pkg::FW_W-1:0]      rect_width,
    input logic [lir_pkg::FH_W-1:0]      rect_height
);

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result word dropped without pop");

    a_word_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(rect_found) && $stable(rect_x) && $stable(rect_y)
                           && $stable(rect_width) && $stable(rect_height))
        else $error("result word changed while waiting");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !rect_found |-> rect_x == '0 && rect_y == '0
                                  && rect_width == '0 && rect_height == '0)
        else $error("empty result carries a rectangle");

    a_found_size: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rect_found |-> rect_width != '0 && rect_height != '0)
        else $error("found rectangle has zero size");

endmodule

bind largest_interior_rectangle lir_checker u_lir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .rect_found  (rect_found),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height)
);
